// ===== src/ihb_pkg.sv =====
// Shared constants, command codes and controller/datapath types for the heat-bath site update.
`timescale 1ns / 1ps

package ihb_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int RAND_BITS = 16;
    localparam int SIDE_W    = 7;
    localparam int SITE_W    = 12;
    localparam int ROW_W     = $clog2(MAX_SIDE);
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int DVS_W     = SIDE_W + ROW_W - 1;
    localparam int CMP_W     = (SITE_W > DVS_W) ? SITE_W : DVS_W;
    localparam int CNT_W     = $clog2(ROW_W);
    localparam int THR_W     = RAND_BITS + 1;
    localparam int NCNT_W    = 3;
    localparam int NPROB     = 4;
    localparam int PIDX_W    = $clog2(NPROB);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [SIDE_W-1:0]    SIDE_RESET = SIDE_W'(64);
    localparam logic [RAND_BITS-1:0] PROB_RESET = RAND_BITS'(32768);
    localparam logic [THR_W-1:0]     THR_FULL   = {1'b1, {RAND_BITS{1'b0}}};
    localparam logic [THR_W-1:0]     THR_HALF   = THR_FULL >> 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_H1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_H2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_H3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_H4   = 3'd4;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [1:0] RD_SEL_UP  = 2'd0;
    localparam logic [1:0] RD_SEL_MID = 2'd1;
    localparam logic [1:0] RD_SEL_DN  = 2'd2;
    localparam logic [1:0] RD_SEL_NBR = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       check;
        logic       div_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
    } t_dp_status;

endpackage

// ===== src/ihb_ifs.sv =====
// Channel interfaces for item beats, result beats and configuration beats.
`timescale 1ns / 1ps

interface ihb_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] site_index;
    logic [15:0] rand_value;
    logic        write_spin;

    modport source (output valid, cmd, site_index, rand_value, write_spin, input ready);
    modport sink (input valid, cmd, site_index, rand_value, write_spin, output ready);
endinterface

interface ihb_result_if;
    logic       valid;
    logic       ready;
    logic       new_spin;
    logic [2:0] plus_count;
    logic [2:0] minus_count;
    logic       index_error;

    modport source (output valid, new_spin, plus_count, minus_count, index_error, input ready);
    modport sink (input valid, new_spin, plus_count, minus_count, index_error, output ready);
endinterface

interface ihb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ihb_datapath.sv =====
// Datapath: configuration registers, spin word memory, row divider and heat-bath decision.
`timescale 1ns / 1ps

module ihb_datapath
    import ihb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_item_cmd,
    input  logic [SITE_W-1:0]    i_item_site,
    input  logic [RAND_BITS-1:0] i_item_rand,
    input  logic                 i_item_wspin,
    output logic                 o_new_spin,
    output logic [NCNT_W-1:0]    o_plus_count,
    output logic [NCNT_W-1:0]    o_minus_count,
    output logic                 o_index_error
);

    logic [SIDE_W-1:0]    r_grid_side;
    logic [RAND_BITS-1:0] r_prob [NPROB];

    logic                 r_cmd;
    logic [SITE_W-1:0]    r_site;
    logic [RAND_BITS-1:0] r_rand;
    logic                 r_wspin;
    logic                 r_err;

    logic [SITE_W-1:0]    r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [ROW_W-1:0]     r_row;

    logic [MAX_SIDE-1:0]  mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]  r_row_vld;
    logic [MAX_SIDE-1:0]  r_rdata;
    logic                 r_rd_vld;
    logic                 r_pend;
    logic [1:0]           r_rd_sel_q;
    logic                 r_up_bit;
    logic                 r_dn_bit;
    logic                 r_nbr_bit;
    logic [MAX_SIDE-1:0]  r_mid;

    logic                 r_new_spin;
    logic [NCNT_W-1:0]    r_plus;
    logic [NCNT_W-1:0]    r_minus;
    logic                 r_out_err;

    logic [SIDE_W-1:0]    side_c;
    logic                 chk_err;
    logic [CMP_W-1:0]     rem_x;
    logic [CMP_W-1:0]     dvs_x;
    logic [ROW_W-1:0]     col;
    logic [ROW_W-1:0]     mid_word;
    logic [ROW_W-1:0]     sbit;
    logic [ROW_W-1:0]     nbr_pos;
    logic [SITE_W-1:0]    up_site;
    logic [SITE_W-1:0]    dn_site;
    logic [ROW_W-1:0]     rd_addr;
    logic [MAX_SIDE-1:0]  w_eff;
    logic                 has_r, has_l, has_u, has_d;
    logic                 bit_r, bit_l;
    logic [NCNT_W-1:0]    plus, minus;
    logic [PIDX_W-1:0]    pidx;
    logic [THR_W-1:0]     thr;
    logic                 spin;
    logic [MAX_SIDE-1:0]  wr_word;
    logic                 wr_en;

    assign side_c  = (r_grid_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_grid_side;
    assign chk_err = (side_c == '0)
                     || (PROD_W'(r_site) >= PROD_W'(side_c) * PROD_W'(side_c));
    assign o_status.err = chk_err;

    assign rem_x = CMP_W'(r_rem);
    assign dvs_x = CMP_W'(r_dvs);
    assign col   = r_rem[ROW_W-1:0];

    // Spins are kept in linear site order, one memory word per MAX_SIDE sites.
    assign mid_word = r_site[SITE_W-1:ROW_W];
    assign sbit     = r_site[ROW_W-1:0];
    assign nbr_pos  = (sbit == '0) ? {ROW_W{1'b1}} : {ROW_W{1'b0}};
    assign up_site  = r_site - SITE_W'(side_c);
    assign dn_site  = r_site + SITE_W'(side_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= SIDE_RESET;
            for (int i = 0; i < NPROB; i++) begin
                r_prob[i] <= PROB_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_SIDE: r_grid_side <= i_cfg_data[SIDE_W-1:0];
                CFG_PROB_H1:   r_prob[0]   <= i_cfg_data[RAND_BITS-1:0];
                CFG_PROB_H2:   r_prob[1]   <= i_cfg_data[RAND_BITS-1:0];
                CFG_PROB_H3:   r_prob[2]   <= i_cfg_data[RAND_BITS-1:0];
                CFG_PROB_H4:   r_prob[3]   <= i_cfg_data[RAND_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_item_cmd;
            r_site  <= i_item_site;
            r_rand  <= i_item_rand;
            r_wspin <= i_item_wspin;
        end
        if (i_cmd.check) begin
            r_err <= chk_err;
            r_rem <= r_site;
            r_dvs <= DVS_W'(side_c) << (ROW_W - 1);
            r_row <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_x >= dvs_x) begin
                r_rem <= SITE_W'(rem_x - dvs_x);
                r_row <= {r_row[ROW_W-2:0], 1'b1};
            end else begin
                r_row <= {r_row[ROW_W-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SEL_UP:  rd_addr = up_site[SITE_W-1:ROW_W];
            RD_SEL_DN:  rd_addr = dn_site[SITE_W-1:ROW_W];
            RD_SEL_NBR: rd_addr = (sbit == '0) ? mid_word - ROW_W'(1)
                                               : mid_word + ROW_W'(1);
            default:    rd_addr = mid_word;
        endcase
    end

    assign w_eff = r_rd_vld ? r_rdata : '1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[mid_word] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_rdata    <= mem[rd_addr];
            r_rd_vld   <= r_row_vld[rd_addr];
            r_rd_sel_q <= i_cmd.rd_sel;
        end
        if (r_pend) begin
            case (r_rd_sel_q)
                RD_SEL_UP:  r_up_bit  <= w_eff[up_site[ROW_W-1:0]];
                RD_SEL_MID: r_mid     <= w_eff;
                RD_SEL_DN:  r_dn_bit  <= w_eff[dn_site[ROW_W-1:0]];
                RD_SEL_NBR: r_nbr_bit <= w_eff[nbr_pos];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_en;
            if (wr_en) begin
                r_row_vld[mid_word] <= 1'b1;
            end
        end
    end

    always_comb begin
        has_r = (SIDE_W'(col) + SIDE_W'(1)) < side_c;
        has_l = (col != '0);
        has_d = (SIDE_W'(r_row) + SIDE_W'(1)) < side_c;
        has_u = (r_row != '0);
        bit_r = (sbit == {ROW_W{1'b1}}) ? r_nbr_bit : r_mid[sbit + ROW_W'(1)];
        bit_l = (sbit == '0) ? r_nbr_bit : r_mid[sbit - ROW_W'(1)];
        plus  = NCNT_W'(has_r & bit_r) + NCNT_W'(has_l & bit_l)
              + NCNT_W'(has_d & r_dn_bit) + NCNT_W'(has_u & r_up_bit);
        minus = NCNT_W'(has_r & ~bit_r) + NCNT_W'(has_l & ~bit_l)
              + NCNT_W'(has_d & ~r_dn_bit) + NCNT_W'(has_u & ~r_up_bit);
        if (plus > minus) begin
            pidx = PIDX_W'(plus - minus - NCNT_W'(1));
            thr  = THR_W'(r_prob[pidx]);
        end else if (minus > plus) begin
            pidx = PIDX_W'(minus - plus - NCNT_W'(1));
            thr  = THR_FULL - THR_W'(r_prob[pidx]);
        end else begin
            pidx = '0;
            thr  = THR_HALF;
        end
        spin = (r_cmd == CMD_WRITE) ? r_wspin : (THR_W'(r_rand) < thr);
        wr_word       = r_mid;
        wr_word[sbit] = spin;
    end

    assign wr_en = i_cmd.finish && !r_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_new_spin <= r_err ? 1'b0 : spin;
            r_plus     <= r_err ? '0 : plus;
            r_minus    <= r_err ? '0 : minus;
            r_out_err  <= r_err;
        end
    end

    assign o_new_spin    = r_new_spin;
    assign o_plus_count  = r_plus;
    assign o_minus_count = r_minus;
    assign o_index_error = r_out_err;

`ifndef SYNTH
    a_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_err) |-> (SIDE_W'(r_row) < side_c))
        else $error("row quotient lies outside the grid");

    a_col_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_rd_sel_q == RD_SEL_UP) |-> (rem_x < CMP_W'(side_c)))
        else $error("division remainder not below the side");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_err) |=> r_row_vld[$past(mid_word)])
        else $error("written word not marked valid");
`endif

endmodule

// ===== src/ihb_ctrl.sv =====
// Controller state machine sequencing check, division, word reads and write-back.
`timescale 1ns / 1ps

module ihb_ctrl
    import ihb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_RD_UP   = 4'd3;
    localparam logic [3:0] S_RD_MID  = 4'd4;
    localparam logic [3:0] S_RD_DN   = 4'd5;
    localparam logic [3:0] S_RD_NBR  = 4'd6;
    localparam logic [3:0] S_RD_WAIT = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = CNT_W'(ROW_W - 1);
                n_state     = i_status.err ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_RD_UP;
                end
            end
            S_RD_UP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SEL_UP;
                n_state      = S_RD_MID;
            end
            S_RD_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SEL_MID;
                n_state      = S_RD_DN;
            end
            S_RD_DN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SEL_DN;
                n_state      = S_RD_NBR;
            end
            S_RD_NBR: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SEL_NBR;
                n_state      = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_vld = o_cmd.finish || (r_out_vld && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

`ifndef SYNTH
    a_err_skips_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_status.err) |=> (r_state == S_DONE))
        else $error("out-of-grid item did not go straight to completion");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_RD_UP))
        else $error("division did not end after its last step");

    a_finish_frees_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_vld || i_out_ready))
        else $error("result loaded over an untaken result");
`endif

endmodule

// ===== src/ising_heat_bath_site_update_unit.sv =====
// Top level of the heat-bath site update unit for a square open-boundary Ising grid.
`timescale 1ns / 1ps

// One item is taken at a time. A site inside the grid passes through the check, the division,
// the four word reads and a wait state before its result is loaded into the output register;
// a site outside the grid goes straight from the check to completion. The time an in-grid item
// takes is set by the row/column split of the site index, a restoring divider that yields one
// row bit per cycle, and by four words
// of the spin memory (the words holding the sites above and below, the site's own word and the
// word beside it) being read one after another through its single port. Spins are held in
// linear site order, 64 to a word, so a change of grid side keeps the spin of every index.
// A new item is accepted while the previous result still waits in the output register. Each
// word of the spin memory has a valid flag cleared by reset, so the grid reads as all +1
// straight after reset with no clearing pass. The configuration port is always ready, but
// it is to be written only while the block is idle; the block itself does not enforce this.
module ising_heat_bath_site_update_unit
    import ihb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ihb_item_if.sink          i_item,
    ihb_result_if.source      o_result,
    ihb_cfg_if.sink           i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;

    ihb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ihb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_item_cmd    (i_item.cmd),
        .i_item_site   (i_item.site_index),
        .i_item_rand   (i_item.rand_value),
        .i_item_wspin  (i_item.write_spin),
        .o_new_spin    (o_result.new_spin),
        .o_plus_count  (o_result.plus_count),
        .o_minus_count (o_result.minus_count),
        .o_index_error (o_result.index_error)
    );

    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;
    assign i_cfg.ready    = 1'b1;

endmodule
